FILE: sv/bls_pkg.sv
// Shared types and constants for the battery level smoother.
// Used by bls_ctrl, bls_dp and battery_level_smoother_unit; no dependencies.
package bls_pkg;

  localparam int unsigned ADC_W        = 12;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned INTERVAL_W   = 20;
  localparam int unsigned LEVEL_W      = 3;
  localparam int unsigned LVL_W        = 16;  // signed instantaneous level
  localparam int unsigned MAG_W        = 15;  // |(adc - floor) * 6| <= 24570
  localparam int unsigned DIV_CNT_W    = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned S_TDATA_W    = 48;
  localparam int unsigned M_TDATA_W    = 8;

  localparam int unsigned DEPTH_DEFAULT = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 3'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_CHARGING = 3'd6;

  localparam logic [ADC_W-1:0]      FLOOR_RST    = 12'd505;
  localparam logic [ADC_W-1:0]      CEILING_RST  = 12'd546;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_FLOOR   = 2'd0,
    REG_ADC_CEILING = 2'd1,
    REG_REFILL_INT  = 2'd2
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // load input beat, set up divider
    logic div_step;  // one restoring division step
    logic lvl_calc;  // sign/cap quotient, evaluate refill
    logic sum_calc;  // new running total
    logic commit;    // update window state, load output
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic charging;
  } dp_status_t;

endpackage

FILE: sv/bls_dp.sv
// Datapath of the battery level smoother: config registers, scaling divider,
// boxcar window and output register. Depends on bls_pkg.
module bls_dp #(
  parameter int unsigned WINDOW_DEPTH = bls_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bls_pkg::dp_cmd_t                    cmd_i,
  output bls_pkg::dp_status_t                 status_o,
  input  logic [bls_pkg::ADC_W-1:0]           adc_sample_i,
  input  logic                                charging_i,
  input  logic [bls_pkg::TIME_W-1:0]          time_ms_i,
  input  logic                                cfg_we_i,
  input  logic [bls_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bls_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [bls_pkg::LEVEL_W-1:0]         level_o
);

  localparam int unsigned LVL_W = bls_pkg::LVL_W;
  localparam int unsigned MAG_W = bls_pkg::MAG_W;
  localparam int unsigned ADC_W = bls_pkg::ADC_W;
  localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned TOT_W = LVL_W + PTR_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic signed [TOT_W-1:0] DEPTH_S = TOT_W'(WINDOW_DEPTH);
  localparam logic signed [LVL_W-1:0] LVL_CAP = LVL_W'(bls_pkg::LEVEL_MAX);

  // config
  logic [ADC_W-1:0]                  floor_q, ceiling_q;
  logic [bls_pkg::INTERVAL_W-1:0]    interval_q;

  // captured beat
  logic                              chg_q;
  logic [bls_pkg::TIME_W-1:0]        time_q;
  logic                              neg_q, degen_q;
  logic [ADC_W-1:0]                  span_q;

  // divider
  logic [MAG_W-1:0]                  dvd_q;
  logic [ADC_W:0]                    rem_q;
  logic [bls_pkg::DIV_CNT_W-1:0]     cnt_q;

  // window state
  logic signed [LVL_W-1:0]           slot_q [WINDOW_DEPTH];
  logic signed [TOT_W-1:0]           total_q, sum_q;
  logic [PTR_W-1:0]                  ptr_q;
  logic                              primed_q, charge_seen_q;
  logic [bls_pkg::TIME_W-1:0]        last_refill_q;
  logic signed [LVL_W-1:0]           lvl_q;
  logic                              refill_q, prime_q;
  logic [bls_pkg::LEVEL_W-1:0]       level_q;

  // capture-time scaling numerator
  logic signed [ADC_W:0]             diff;
  logic signed [LVL_W-1:0]           num;
  logic [LVL_W-1:0]                  num_abs;

  assign diff    = $signed({1'b0, adc_sample_i}) - $signed({1'b0, floor_q});
  assign num     = ($signed(LVL_W'(diff)) <<< 2) + ($signed(LVL_W'(diff)) <<< 1);
  assign num_abs = num[LVL_W-1] ? LVL_W'(-num) : LVL_W'(num);

  // restoring division step
  logic [ADC_W:0] rem_sh;
  logic           q_bit;
  assign rem_sh = {rem_q[ADC_W-1:0], dvd_q[MAG_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, span_q});

  // signed, capped quotient
  logic signed [LVL_W-1:0] quo_s, lvl_d;
  assign quo_s = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  always_comb begin
    if (degen_q) begin
      lvl_d = '0;
    end else if (quo_s > LVL_CAP) begin
      lvl_d = LVL_CAP;
    end else begin
      lvl_d = quo_s;
    end
  end

  logic [bls_pkg::TIME_W-1:0] age;
  assign age = time_q - last_refill_q;

  logic signed [TOT_W-1:0] lvl_ext;
  assign lvl_ext = TOT_W'(lvl_q);

  // clamp(lvl) to 0..LEVEL_MAX (lvl already capped above)
  function automatic logic [bls_pkg::LEVEL_W-1:0] clamp_lvl(input logic signed [LVL_W-1:0] v);
    logic [bls_pkg::LEVEL_W-1:0] r;
    r = v[LVL_W-1] ? '0 : v[bls_pkg::LEVEL_W-1:0];
    return r;
  endfunction

  // round(total / depth) half away from zero, clamped to 0..LEVEL_MAX:
  // result >= k exactly when 2*total >= depth*(2k-1)
  function automatic logic [bls_pkg::LEVEL_W-1:0] round_clamp(
      input logic signed [TOT_W-1:0] t);
    logic [TOT_W:0]              t2;
    logic [bls_pkg::LEVEL_W-1:0] r;
    t2 = {t, 1'b0};
    r  = '0;
    if (!t[TOT_W-1]) begin
      for (int k = 1; k <= int'(bls_pkg::LEVEL_MAX); k++) begin
        if (t2 >= (TOT_W+1)'(WINDOW_DEPTH * (2 * k - 1))) r = bls_pkg::LEVEL_W'(k);
      end
    end
    return r;
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q    <= bls_pkg::FLOOR_RST;
      ceiling_q  <= bls_pkg::CEILING_RST;
      interval_q <= bls_pkg::INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (bls_pkg::cfg_reg_e'(cfg_index_i))
        bls_pkg::REG_ADC_FLOOR:   floor_q    <= cfg_data_i[ADC_W-1:0];
        bls_pkg::REG_ADC_CEILING: ceiling_q  <= cfg_data_i[ADC_W-1:0];
        bls_pkg::REG_REFILL_INT:  interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.capture) begin
      cnt_q <= bls_pkg::DIV_CNT_W'(MAG_W);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      chg_q   <= charging_i;
      time_q  <= time_ms_i;
      neg_q   <= num[LVL_W-1];
      degen_q <= (ceiling_q <= floor_q);
      span_q  <= ceiling_q - floor_q;
      dvd_q   <= num_abs[MAG_W-1:0];
      rem_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? (rem_sh - {1'b0, span_q}) : rem_sh;
      dvd_q <= {dvd_q[MAG_W-2:0], q_bit};
    end
    if (cmd_i.lvl_calc) begin
      lvl_q    <= lvl_d;
      refill_q <= (age > bls_pkg::TIME_W'(interval_q)) || charge_seen_q;
    end
    if (cmd_i.sum_calc) begin
      prime_q <= refill_q || !primed_q;
      if (refill_q || !primed_q) begin
        sum_q <= lvl_ext * DEPTH_S;
      end else begin
        sum_q <= total_q - TOT_W'(slot_q[ptr_q]) + lvl_ext;
      end
    end
  end

  // window slots: primed all at once, otherwise one slot per item
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !chg_q) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (prime_q || (ptr_q == PTR_W'(i))) slot_q[i] <= lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q       <= '0;
      ptr_q         <= '0;
      primed_q      <= 1'b0;
      charge_seen_q <= 1'b0;
      last_refill_q <= '0;
      level_q       <= '0;
    end else if (cmd_i.commit) begin
      if (chg_q) begin
        charge_seen_q <= 1'b1;
        level_q       <= bls_pkg::LEVEL_CHARGING;
      end else begin
        if (refill_q) begin
          charge_seen_q <= 1'b0;
          last_refill_q <= time_q;
        end
        primed_q <= 1'b1;
        total_q  <= sum_q;
        if (prime_q) begin
          ptr_q   <= '0;
          level_q <= clamp_lvl(lvl_q);
        end else begin
          ptr_q   <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
          level_q <= round_clamp(sum_q);
        end
      end
    end
  end

  assign status_o.div_done = (cnt_q == '0);
  assign status_o.charging = chg_q;
  assign level_o           = level_q;

endmodule

FILE: sv/bls_ctrl.sv
// Sequencing FSM of the battery level smoother: input/output handshake and
// datapath commands. Depends on bls_pkg.
module bls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bls_pkg::dp_cmd_t    cmd_o,
  input  bls_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LVL,
    ST_SUM,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV) && !status_i.charging && !status_i.div_done;
    cmd_o.lvl_calc = (state_q == ST_LVL);
    cmd_o.sum_calc = (state_q == ST_SUM);
    cmd_o.commit   = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_DIV;
        ST_DIV: begin
          if (status_i.charging)      state_q <= ST_OUT;
          else if (status_i.div_done) state_q <= ST_LVL;
        end
        ST_LVL: state_q <= ST_SUM;
        ST_SUM: state_q <= ST_OUT;
        ST_OUT: if (out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (state_q == ST_OUT) && (!out_valid_q || out_ready_i))
    else $error("result committed while output slot occupied");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DIV))
    else $error("accepted beat did not start the divider");

  a_div_to_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && status_i.div_done && !status_i.charging) |=> (state_q == ST_LVL))
    else $error("finished division did not advance");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("commit did not raise output valid");

endmodule

FILE: sv/battery_level_smoother_unit.sv
// The bit-serial scaling divider produces one quotient bit per cycle over 15
// bits; charging beats skip it. A new input beat is taken only after the
// previous one has been committed to the output register.
// The output register lets the next input beat be taken while a result waits.
// Reset (rst_ni, async, active low): config returns to floor 505, ceiling 546,
// refill interval 10000 ms; window unprimed, last refill time zero.
module battery_level_smoother_unit #(
  parameter int unsigned WINDOW_DEPTH = bls_pkg::DEPTH_DEFAULT  // 2..16 slots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bls_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,  // [11:0] adc_sample, [43:12] time_ms, rest 0
  input  logic                               s_axis_tuser_i,  // [0] charging
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [bls_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,  // [2:0] level, rest 0
  // register writes: 0 adc_floor, 1 adc_ceiling, 2 refill_interval_ms
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bls_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  bls_pkg::dp_cmd_t            cmd;
  bls_pkg::dp_status_t         status;
  logic [bls_pkg::LEVEL_W-1:0] level;

  // registers are plain flops, a write is always accepted and registered
  assign cfg_ready_o = 1'b1;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  bls_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .adc_sample_i (s_axis_tdata_i[bls_pkg::ADC_W-1:0]),
    .charging_i   (s_axis_tuser_i),
    .time_ms_i    (s_axis_tdata_i[bls_pkg::ADC_W +: bls_pkg::TIME_W]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .level_o      (level)
  );

  assign m_axis_tdata_o = bls_pkg::M_TDATA_W'(level);

endmodule
